// ===== rtl/ppfr_pkg.sv =====
package ppfr_pkg;

  localparam int QUEUE_SLOTS_DEF  = 16;
  localparam int PAIRS_PER_PACKET = 122;
  localparam int FRAME_LEN        = 512;
  localparam int POS_W            = 9;
  localparam int SAMPLE_W         = 16;
  localparam int FRAMES_W         = 4;
  localparam int PAIR_W           = $clog2(PAIRS_PER_PACKET);
  localparam int CHANNELS         = 3;

  localparam logic [POS_W-1:0] ODD_SHIFT = 9'd244;
  localparam logic [POS_W-1:0] PAD_LOW   = 9'd12;
  localparam logic [POS_W-1:0] PAD_HIGH  = 9'd500;
  localparam logic [2:0]       LAST_LANE = 3'd5;
  localparam logic [1:0]       CH_LIMIT  = 2'd3;

  typedef enum logic [1:0] {
    OP_WORD    = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_READ_OK   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_COMMITTED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_READ
  } ctl_state_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic lookup;
    logic finish_read;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic go_lookup;
    logic go_read;
  } dp_stat_t;

endpackage

// ===== rtl/ppfr_ram.sv =====
module ppfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ppfr_ctrl.sv =====
module ppfr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ppfr_pkg::dp_stat_t stat,
  output ppfr_pkg::ctl_cmd_t cmd
);

  import ppfr_pkg::*;

  ctl_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          if (stat.go_read) begin
            state_next = S_READ;
          end else begin
            // result known at once, number lookup follows in S_LOOKUP
            cmd.load_out   = 1'b1;
            out_valid_next = 1'b1;
            if (stat.go_lookup) begin
              state_next = S_LOOKUP;
            end
          end
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_IDLE;
      end
      S_READ: begin
        cmd.finish_read = 1'b1;
        cmd.load_out    = 1'b1;
        out_valid_next  = 1'b1;
        state_next      = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ===== rtl/ppfr_datapath.sv =====
module ppfr_datapath #(
  parameter int QUEUE_SLOTS = ppfr_pkg::QUEUE_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ppfr_pkg::ctl_cmd_t                  cmd,
  output ppfr_pkg::dp_stat_t                  stat,
  input  logic [1:0]                          op,
  input  logic                                first,
  input  logic signed [ppfr_pkg::SAMPLE_W-1:0] word,
  input  logic [1:0]                          channel,
  input  logic [ppfr_pkg::POS_W-1:0]          sample_index,
  output logic signed [ppfr_pkg::SAMPLE_W-1:0] sample,
  output logic [2:0]                          status,
  output logic [ppfr_pkg::FRAMES_W-1:0]       frames_held
);

  import ppfr_pkg::*;

  localparam int SW          = $clog2(QUEUE_SLOTS);
  localparam int ROWS        = QUEUE_SLOTS * CHANNELS;
  localparam int RW          = $clog2(ROWS);
  localparam int STORE_DEPTH = ROWS * FRAME_LEN;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_SLOTS - 1);
  localparam logic [SW:0]   SLOTS_EXT = (SW + 1)'(QUEUE_SLOTS);

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [RW-1:0] row_of(input logic [SW-1:0] s, input logic [1:0] ch);
    logic [SW+1:0] r;
    r = {1'b0, s, 1'b0} + {2'b00, s} + {{SW{1'b0}}, ch};
    return r[RW-1:0];
  endfunction

  // state
  logic [SW-1:0]       head_slot, head_next;
  logic [SW-1:0]       tail_slot, tail_next;
  logic [SW-1:0]       clr_addr;
  logic [PAIR_W-1:0]   pair_cnt, pair_next;
  logic [2:0]          lane_cnt, lane_next;
  logic                words_done, words_done_next;
  logic                odd_half, odd_next;
  logic                drop_packet, drop_next;
  logic                pair_match, pair_match_next;
  logic [SAMPLE_W-1:0] pending_number, pending_next;
  logic                read_ok, read_ok_next;

  // memory ports
  logic                st_we, st_re;
  logic [AW-1:0]       st_waddr, st_raddr;
  logic [SAMPLE_W-1:0] st_rdata;
  logic                sn_we, sn_re;
  logic [SW-1:0]       sn_waddr;
  logic [SAMPLE_W-1:0] sn_wdata, sn_rdata;

  logic          full, empty, in_range, last_word, number_hit;
  logic [POS_W-1:0] wpos;
  status_t       res;
  logic [SW:0]   held;
  logic [SW+FRAMES_W:0] held_ext;

  assign full     = (head_slot == next_slot(tail_slot));
  assign empty    = (head_slot == tail_slot);
  assign in_range = (channel < CH_LIMIT) && (sample_index >= PAD_LOW) &&
                    (sample_index < PAD_HIGH);
  assign last_word = (pair_cnt == PAIR_W'(PAIRS_PER_PACKET - 1)) && (lane_cnt == LAST_LANE);
  assign wpos     = {1'b0, pair_cnt, lane_cnt[0]} + PAD_LOW + (odd_half ? ODD_SHIFT : '0);
  assign st_waddr = AW'({row_of(tail_slot, lane_cnt[2:1]), wpos});
  assign st_raddr = AW'({row_of(head_slot, channel), sample_index});
  assign number_hit = ({sn_rdata[SAMPLE_W-1], sn_rdata} + 1'b1) ==
                      {pending_number[SAMPLE_W-1], pending_number};

  assign stat.clear_last = (clr_addr == LAST_SLOT);
  assign stat.go_lookup  = (op == OP_WORD) && first && !full;
  assign stat.go_read    = (op == OP_READ) && !empty;

  always_comb begin
    head_next       = head_slot;
    tail_next       = tail_slot;
    pair_next       = pair_cnt;
    lane_next       = lane_cnt;
    words_done_next = words_done;
    odd_next        = odd_half;
    drop_next       = drop_packet;
    pair_match_next = pair_match;
    pending_next    = pending_number;
    read_ok_next    = read_ok;
    res             = ST_ACCEPTED;
    st_we           = 1'b0;
    st_re           = 1'b0;
    sn_re           = 1'b0;
    sn_we           = cmd.clear;
    sn_waddr        = cmd.clear ? clr_addr : tail_slot;
    sn_wdata        = cmd.clear ? '0 : pending_number;
    if (cmd.take) begin
      case (op)
        OP_WORD: begin
          if (first) begin
            pair_next       = '0;
            lane_next       = '0;
            words_done_next = 1'b0;
            if (full) begin
              drop_next = 1'b1;
              res       = ST_DROPPED;
            end else begin
              drop_next    = 1'b0;
              pending_next = word;
              odd_next     = word[0];
              sn_re        = 1'b1;
            end
          end else if (drop_packet) begin
            res = ST_DROPPED;
          end else if (!words_done) begin
            st_we = 1'b1;
            if (lane_cnt == LAST_LANE) begin
              lane_next = '0;
              pair_next = pair_cnt + 1'b1;
            end else begin
              lane_next = lane_cnt + 1'b1;
            end
            if (last_word) begin
              words_done_next = 1'b1;
              if (pair_match) begin
                tail_next = next_slot(tail_slot);
                res       = ST_COMMITTED;
              end else begin
                sn_we = 1'b1;
              end
            end
          end
        end
        OP_READ: begin
          if (empty) begin
            res = ST_EMPTY;
          end else begin
            st_re        = 1'b1;
            read_ok_next = in_range;
          end
        end
        OP_RELEASE: begin
          if (empty) begin
            res = ST_EMPTY;
          end else begin
            head_next = next_slot(head_slot);
          end
        end
        default: res = ST_ACCEPTED;
      endcase
    end
    if (cmd.lookup) begin
      pair_match_next = odd_half && number_hit;
    end
  end

  // ring occupancy after this step
  assign held     = (tail_next >= head_next) ? {1'b0, tail_next} - {1'b0, head_next}
                                             : {1'b0, tail_next} + SLOTS_EXT - {1'b0, head_next};
  assign held_ext = {{FRAMES_W{1'b0}}, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot   <= '0;
      tail_slot   <= '0;
      clr_addr    <= '0;
      pair_cnt    <= '0;
      lane_cnt    <= '0;
      words_done  <= 1'b0;
      odd_half    <= 1'b0;
      drop_packet <= 1'b1;
      pair_match  <= 1'b0;
    end else begin
      head_slot   <= head_next;
      tail_slot   <= tail_next;
      pair_cnt    <= pair_next;
      lane_cnt    <= lane_next;
      words_done  <= words_done_next;
      odd_half    <= odd_next;
      drop_packet <= drop_next;
      pair_match  <= pair_match_next;
      if (cmd.clear && !stat.clear_last) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pending_number <= pending_next;
    read_ok        <= read_ok_next;
    if (cmd.load_out) begin
      sample      <= (cmd.finish_read && read_ok) ? st_rdata : '0;
      status      <= cmd.finish_read ? ST_READ_OK : res;
      frames_held <= held_ext[FRAMES_W-1:0];
    end
  end

  ppfr_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(STORE_DEPTH)
  ) u_sample_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(word),
    .re   (st_re),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  ppfr_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(QUEUE_SLOTS)
  ) u_slot_numbers (
    .clk  (clk),
    .we   (sn_we),
    .waddr(sn_waddr),
    .wdata(sn_wdata),
    .re   (sn_re),
    .raddr(tail_slot),
    .rdata(sn_rdata)
  );

endmodule

// ===== rtl/packet_pair_frame_ring_top.sv =====
// Packet-to-frame ring: packet words (sequence number, then 732 samples) are scattered
// into the tail slot of a ring of QUEUE_SLOTS frames of 3 x 512 samples; an odd packet
// whose number follows the number stored for the tail slot commits the frame on its
// last word. Sample words, releases, unused ops, reads and releases on an empty ring
// and sequence-number words dropped by a full ring are answered straight from S_IDLE,
// so a packet streams in at one word per cycle when the result side keeps up. A
// sequence-number word that opens a packet is followed by S_LOOKUP (registered read
// of the slot-number RAM), and a sample read of a non-empty ring goes through
// S_READ (registered read of the sample store). After reset, in_ready stays low
// while the slot-number RAM is cleared, one entry per cycle.
module packet_pair_frame_ring_top #(
  parameter int QUEUE_SLOTS = ppfr_pkg::QUEUE_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           op,
  input  logic                                 first,
  input  logic signed [ppfr_pkg::SAMPLE_W-1:0] word,
  input  logic [1:0]                           channel,
  input  logic [ppfr_pkg::POS_W-1:0]           sample_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ppfr_pkg::SAMPLE_W-1:0] sample,
  output logic [2:0]                           status,
  output logic [ppfr_pkg::FRAMES_W-1:0]        frames_held
);

  import ppfr_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ppfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppfr_datapath #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .op          (op),
    .first       (first),
    .word        (word),
    .channel     (channel),
    .sample_index(sample_index),
    .sample      (sample),
    .status      (status),
    .frames_held (frames_held)
  );

endmodule

// ===== rtl/ppfr_checker.sv =====
module ppfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] sample,
  input logic [2:0]  status,
  input logic [3:0]  frames_held
);

  import ppfr_pkg::*;

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(status) &&
                                $stable(frames_held))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_sample_only_on_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_READ_OK |-> sample == '0)
    else $error("nonzero sample without a successful read");

  a_empty_none_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> frames_held == '0)
    else $error("empty status while frames are held");

  a_commit_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_COMMITTED || status == ST_READ_OK) |-> frames_held != '0)
    else $error("commit or read with no frame held");

endmodule

bind packet_pair_frame_ring_top ppfr_checker u_ppfr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample     (sample),
  .status     (status),
  .frames_held(frames_held)
);
